// ----- rtl/pstd_pkg.sv -----
// shared types and constants for the trial-division prime summer
package pstd_pkg;

    localparam int LIMIT_BITS_DEF = 12;
    localparam int SUM_BITS_DEF   = 24;

    localparam int FIRST_CANDIDATE = 2;
    localparam int FIRST_DIVISOR   = 2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_NEXT_M,
        S_TEST,
        S_WAIT_REM,
        S_FINISH
    } t_state;

    typedef struct packed {
        logic done;
        logic zero;
    } t_rem_status;

endpackage

// ----- rtl/pstd_rem.sv -----
// iterative restoring remainder unit, one quotient bit per cycle
module pstd_rem
    import pstd_pkg::*;
#(
    parameter int W = LIMIT_BITS_DEF + 1
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [W-1:0] i_dividend,
    input  logic [W-1:0] i_divisor,
    output t_rem_status  o_status
);

    localparam int CW = $clog2(W + 1);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [W-1:0]  r_rem;
    logic [W-1:0]  r_shift;
    logic [W-1:0]  r_div;

    logic [W:0]    trial;
    logic [W:0]    diff;
    logic [W-1:0]  n_rem;

    always_comb begin
        trial = {r_rem, r_shift[W-1]};
        diff  = trial - {1'b0, r_div};
        if (trial >= {1'b0, r_div}) begin
            n_rem = diff[W-1:0];
        end else begin
            n_rem = trial[W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == CW'(1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem   <= '0;
            r_shift <= i_dividend;
            r_div   <= i_divisor;
        end else if (r_busy) begin
            r_rem   <= n_rem;
            r_shift <= {r_shift[W-2:0], 1'b0};
        end
    end

    assign o_status.done = r_done;
    assign o_status.zero = (r_rem == '0);

endmodule

// ----- rtl/prime_sum_trial_division.sv -----
// sum of primes up to a limit, by trial division with a shared remainder unit
//
// input channel: i_valid / o_ready carry one limit n on i_limit; the block
// takes an item only while it is idle and drops o_ready until the sum of all
// primes from 2 through n has been handed to its output register.
// output channel: o_valid / i_ready carry the total on o_prime_total; the
// result register holds its value until the transfer, and a new limit may be
// accepted while a finished total still waits there.
// each candidate m from 2 through n is tested with divisors d = 2, 3, ...
// while d*d <= m, stopping at the first exact divisor. every trial runs one
// remainder through the shared restoring unit, sequenced by the S_TEST and
// S_WAIT_REM states. there is no overlap between items.
// the total saturates at all ones if it outgrows SUM_BITS.
// reset (synchronous, active low) returns the sequencer to idle, drops the
// result valid flag and stops the remainder unit; data registers have no reset.
module prime_sum_trial_division
    import pstd_pkg::*;
#(
    parameter int LIMIT_BITS = LIMIT_BITS_DEF,
    parameter int SUM_BITS   = SUM_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [LIMIT_BITS-1:0] i_limit,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [SUM_BITS-1:0]   o_prime_total
);

    localparam int W  = LIMIT_BITS + 1;
    localparam int SQ = 2 * W;
    localparam int AW = ((SUM_BITS > W) ? SUM_BITS : W) + 1;

    t_state              r_state, n_state;
    logic [LIMIT_BITS-1:0] r_n;
    logic [W-1:0]        r_m, n_m;
    logic [W-1:0]        r_d, n_d;
    logic [SQ-1:0]       r_sq, n_sq;
    logic [SUM_BITS-1:0] r_total, n_total;
    logic [SUM_BITS-1:0] r_out;
    logic                r_out_valid;

    logic                rem_start;
    logic                load_out;
    logic                in_xfer;
    logic                m_in_range;
    logic                sq_above;
    logic [AW-1:0]       sum_ext;
    t_rem_status         rem_status;

    assign in_xfer    = i_valid && o_ready;
    assign m_in_range = ({1'b0, r_n} >= r_m);
    assign sq_above   = (r_sq > SQ'(r_m));
    assign sum_ext    = AW'(r_total) + AW'(r_m);

    pstd_rem #(
        .W(W)
    ) u_rem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (rem_start),
        .i_dividend (r_m),
        .i_divisor  (r_d),
        .o_status   (rem_status)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_xfer) n_state = S_NEXT_M;
            end
            S_NEXT_M: begin
                n_state = m_in_range ? S_TEST : S_FINISH;
            end
            S_TEST: begin
                n_state = sq_above ? S_NEXT_M : S_WAIT_REM;
            end
            S_WAIT_REM: begin
                if (rem_status.done) begin
                    n_state = rem_status.zero ? S_NEXT_M : S_TEST;
                end
            end
            S_FINISH: begin
                if (!r_out_valid || i_ready) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // outputs and datapath
    always_comb begin
        n_m       = r_m;
        n_d       = r_d;
        n_sq      = r_sq;
        n_total   = r_total;
        rem_start = 1'b0;
        load_out  = 1'b0;
        o_ready   = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                n_m     = W'(FIRST_CANDIDATE);
                n_total = '0;
            end
            S_NEXT_M: begin
                n_d  = W'(FIRST_DIVISOR);
                n_sq = SQ'(FIRST_DIVISOR * FIRST_DIVISOR);
            end
            S_TEST: begin
                if (sq_above) begin
                    // no divisor found: prime
                    if (sum_ext > AW'({SUM_BITS{1'b1}})) begin
                        n_total = {SUM_BITS{1'b1}};
                    end else begin
                        n_total = sum_ext[SUM_BITS-1:0];
                    end
                    n_m = r_m + W'(1);
                end else begin
                    rem_start = 1'b1;
                end
            end
            S_WAIT_REM: begin
                if (rem_status.done) begin
                    if (rem_status.zero) begin
                        n_m = r_m + W'(1);
                    end else begin
                        n_d  = r_d + W'(1);
                        n_sq = r_sq + (SQ'(r_d) << 1) + SQ'(1);
                    end
                end
            end
            S_FINISH: begin
                load_out = !r_out_valid || i_ready;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) r_n <= i_limit;
        if (load_out) r_out <= r_total;
        r_m     <= n_m;
        r_d     <= n_d;
        r_sq    <= n_sq;
        r_total <= n_total;
    end

    assign o_valid       = r_out_valid;
    assign o_prime_total = r_out;

endmodule

// ----- rtl/pstd_checker.sv -----
// port-level assertions for the prime summer, bound to the top level
module pstd_checker
    import pstd_pkg::*;
#(
    parameter int LIMIT_BITS = LIMIT_BITS_DEF,
    parameter int SUM_BITS   = SUM_BITS_DEF
) (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_valid,
    input logic                  o_ready,
    input logic [LIMIT_BITS-1:0] i_limit,
    input logic                  o_valid,
    input logic                  i_ready,
    input logic [SUM_BITS-1:0]   o_prime_total
);

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_prime_total))
        else $error("result changed or dropped while stalled");

    // busy right after an input transfer
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("ready still high after input transfer");

    // a new result only appears at the end of a busy spell
    a_result_from_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(!o_ready))
        else $error("result appeared while idle");

endmodule

bind prime_sum_trial_division pstd_checker #(
    .LIMIT_BITS(LIMIT_BITS),
    .SUM_BITS  (SUM_BITS)
) u_pstd_checker (.*);
